/* design/pot_pkg.sv */
// Shared types, widths, codes and helper functions for the perceptron trainer.
// Depends on nothing; every other design file refers to it by scoped names.
package pot_pkg;

    // Field and datapath widths.
    localparam int FEAT_SLOTS       = 4;
    localparam int FEAT_W           = 16;
    localparam int LR_W             = 16;
    localparam int WEIGHT_W         = 32;
    localparam int STEP_W           = LR_W + 1 + FEAT_W;
    localparam int PROD_W           = WEIGHT_W + FEAT_W;
    localparam int SUM_W            = PROD_W + 4;
    localparam int BIAS_SHIFT       = 8;
    localparam int CNT_W            = 16;
    localparam int FUNC_W           = 2;
    localparam int CFG_IDX_W        = 1;
    localparam int S_TDATA_W        = 72;
    localparam int M_TDATA_W        = 24;
    localparam int WIDE_W           = WEIGHT_W + 3;

    // Defaults for the top-level parameter and the configuration registers.
    localparam int NUM_FEATURES_DEF = 2;
    localparam logic [LR_W-1:0]  LR_RESET         = 16'd6554;
    localparam logic [CNT_W-1:0] MAX_EPOCHS_RESET = 16'd100;
    localparam logic [CNT_W-1:0] CNT_MAX          = '1;

    // Item kinds; the unused code is handled as a classify item.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TRAIN    = 2'd0,
        FUNC_CLASSIFY = 2'd1,
        FUNC_CLEAR    = 2'd2
    } t_func;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEARNING_RATE = 1'b0,
        REG_MAX_EPOCHS    = 1'b1
    } t_reg_idx;

    // Per-lane update control issued by the top-level compute stage.
    typedef struct packed {
        logic update;
        logic label_pos;
        logic clear;
    } t_lane_ctl;

    // Clamp a widened sum to the signed weight range.
    function automatic logic signed [WEIGHT_W-1:0] sat_weight(
        input logic signed [WIDE_W-1:0] r
    );
        logic same;
        same = (r[WIDE_W-1:WEIGHT_W-1] == '0) || (r[WIDE_W-1:WEIGHT_W-1] == '1);
        if (same) begin
            return r[WEIGHT_W-1:0];
        end else if (r[WIDE_W-1]) begin
            return {1'b1, {(WEIGHT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
    endfunction

    // Counter increment that sticks at all ones.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

/* design/pot_lane.sv */
// One feature lane: holds one weight, the captured feature and its learning step,
// forms the weight-feature product and applies the saturating update. Uses pot_pkg.
module pot_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  logic signed [pot_pkg::FEAT_W-1:0]   i_feature,
    input  logic        [pot_pkg::LR_W-1:0]     i_lr,
    input  pot_pkg::t_lane_ctl                  i_ctl,
    output logic signed [pot_pkg::PROD_W-1:0]   o_prod
);

    logic signed [pot_pkg::FEAT_W-1:0]   r_x;
    logic signed [pot_pkg::STEP_W-1:0]   r_step;
    logic signed [pot_pkg::WEIGHT_W-1:0] r_weight;
    logic signed [pot_pkg::WEIGHT_W-1:0] n_weight;
    logic signed [pot_pkg::STEP_W-1:0]   n_step;
    logic signed [pot_pkg::LR_W:0]       lr_s;
    logic signed [pot_pkg::WIDE_W-1:0]   w_ext;
    logic signed [pot_pkg::WIDE_W-1:0]   s_ext;
    logic signed [pot_pkg::WEIGHT_W-1:0] w_up;
    logic signed [pot_pkg::WEIGHT_W-1:0] w_dn;

    // The learning step does not depend on the weight, so it is formed at capture.
    assign lr_s   = $signed({1'b0, i_lr});
    assign n_step = lr_s * i_feature;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x    <= i_feature;
            r_step <= n_step;
        end
    end

    // Product for the merge tree.
    assign o_prod = r_weight * r_x;

    // Both update candidates are ready before the prediction settles.
    assign w_ext = {{(pot_pkg::WIDE_W-pot_pkg::WEIGHT_W){r_weight[pot_pkg::WEIGHT_W-1]}},
                    r_weight};
    assign s_ext = {{(pot_pkg::WIDE_W-pot_pkg::STEP_W){r_step[pot_pkg::STEP_W-1]}}, r_step};
    assign w_up  = pot_pkg::sat_weight(w_ext + s_ext);
    assign w_dn  = pot_pkg::sat_weight(w_ext - s_ext);

    always_comb begin
        n_weight = r_weight;
        if (i_ctl.clear) begin
            n_weight = '0;
        end else if (i_ctl.update) begin
            n_weight = i_ctl.label_pos ? w_up : w_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else begin
            r_weight <= n_weight;
        end
    end

endmodule

/* design/pot_merge.sv */
// Merge stage: adds the lane products and the scaled bias and takes the sign
// as the prediction. Uses pot_pkg.
module pot_merge #(
    parameter int NUM_FEATURES = pot_pkg::NUM_FEATURES_DEF
) (
    input  logic signed [pot_pkg::PROD_W-1:0]   i_prod [NUM_FEATURES],
    input  logic signed [pot_pkg::WEIGHT_W-1:0] i_bias,
    output logic                                o_pred_pos
);

    logic signed [pot_pkg::SUM_W-1:0] sum;

    // Exact sum: bias in the product scale plus every lane product.
    always_comb begin
        sum = {{(pot_pkg::SUM_W-pot_pkg::WEIGHT_W-pot_pkg::BIAS_SHIFT)
                {i_bias[pot_pkg::WEIGHT_W-1]}},
               i_bias, {pot_pkg::BIAS_SHIFT{1'b0}}};
        for (int i = 0; i < NUM_FEATURES; i++) begin
            sum = sum + pot_pkg::SUM_W'(i_prod[i]);
        end
    end

    assign o_pred_pos = !sum[pot_pkg::SUM_W-1];

endmodule

/* design/perceptron_online_trainer.sv */
// Online perceptron trainer, top level: input stage, feature lanes, merge, counters.
// A beat passes the capture stage, then the result register. Throughput: one item
// per cycle unless the result stream stalls; the weight loop (product, sum tree,
// sign, weight select) is combinational, so every item sees the previous item's update.
// Reset clears weights, bias, both counters and all valid flags; the learning rate
// returns to 6554 and the epoch limit to 100. Depends on pot_pkg, pot_lane, pot_merge.
module perceptron_online_trainer #(
    parameter int NUM_FEATURES = pot_pkg::NUM_FEATURES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: feature_0, feature_1, feature_2, feature_3, label, zero fill
    input  logic [pot_pkg::S_TDATA_W-1:0]       i_s_tdata,
    // tuser: func
    input  logic [pot_pkg::FUNC_W-1:0]          i_s_tuser,
    input  logic                                i_s_tlast,
    // Result stream; tlast carries epoch_done.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: predicted, mistake, epoch_mistakes, converged, limit_reached, zero fill
    output logic [pot_pkg::M_TDATA_W-1:0]       o_m_tdata,
    output logic                                o_m_tlast,
    // Configuration writes.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pot_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pot_pkg::LR_W-1:0]            i_cfg_data
);

    logic s_fire;
    logic b_fire;

    // Configuration registers.
    logic [pot_pkg::LR_W-1:0]  r_lr;
    logic [pot_pkg::CNT_W-1:0] r_max_epochs;

    // Capture stage.
    logic                        r_a_vld;
    logic [pot_pkg::FUNC_W-1:0]  r_a_func;
    logic                        r_a_label;
    logic                        r_a_end;

    // Training state.
    logic signed [pot_pkg::WEIGHT_W-1:0] r_bias;
    logic signed [pot_pkg::WEIGHT_W-1:0] n_bias;
    logic [pot_pkg::CNT_W-1:0]           r_mistakes;
    logic [pot_pkg::CNT_W-1:0]           n_mistakes;
    logic [pot_pkg::CNT_W-1:0]           r_epochs;
    logic [pot_pkg::CNT_W-1:0]           n_epochs;

    // Result register.
    logic                        r_o_vld;
    logic                        r_o_pred;
    logic                        r_o_miss;
    logic [pot_pkg::CNT_W-1:0]   r_o_shown;
    logic                        r_o_done;
    logic                        r_o_conv;
    logic                        r_o_lim;
    logic                        n_pred;
    logic                        n_miss;
    logic [pot_pkg::CNT_W-1:0]   n_shown;
    logic                        n_done;
    logic                        n_conv;
    logic                        n_lim;

    logic                                pred_pos;
    logic signed [pot_pkg::PROD_W-1:0]   prod [NUM_FEATURES];
    pot_pkg::t_lane_ctl                  lane_ctl;
    logic signed [pot_pkg::WIDE_W-1:0]   b_ext;
    logic signed [pot_pkg::WIDE_W-1:0]   db_ext;
    logic [pot_pkg::CNT_W-1:0]           cnt_inc;

    // Handshakes: the compute stage moves whenever the result register frees up.
    assign b_fire      = r_a_vld && (!r_o_vld || i_m_tready);
    assign o_s_tready  = !r_a_vld || b_fire;
    assign s_fire      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr         <= pot_pkg::LR_RESET;
            r_max_epochs <= pot_pkg::MAX_EPOCHS_RESET;
        end else if (i_cfg_valid) begin
            case (pot_pkg::t_reg_idx'(i_cfg_index))
                pot_pkg::REG_LEARNING_RATE: r_lr         <= i_cfg_data;
                pot_pkg::REG_MAX_EPOCHS:    r_max_epochs <= i_cfg_data;
                default:                    r_lr         <= r_lr;
            endcase
        end
    end

    // Capture stage control and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (s_fire) begin
            r_a_vld <= 1'b1;
        end else if (b_fire) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_func  <= i_s_tuser;
            r_a_label <= i_s_tdata[pot_pkg::FEAT_SLOTS*pot_pkg::FEAT_W];
            r_a_end   <= i_s_tlast;
        end
    end

    // Feature lanes.
    for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
        pot_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_load    (s_fire),
            .i_feature (i_s_tdata[g*pot_pkg::FEAT_W +: pot_pkg::FEAT_W]),
            .i_lr      (r_lr),
            .i_ctl     (lane_ctl),
            .o_prod    (prod[g])
        );
    end

    pot_merge #(
        .NUM_FEATURES (NUM_FEATURES)
    ) u_merge (
        .i_prod     (prod),
        .i_bias     (r_bias),
        .o_pred_pos (pred_pos)
    );

    // Bias step is the learning rate moved into the weight scale.
    assign b_ext   = {{(pot_pkg::WIDE_W-pot_pkg::WEIGHT_W){r_bias[pot_pkg::WEIGHT_W-1]}},
                      r_bias};
    assign db_ext  = {{(pot_pkg::WIDE_W-pot_pkg::LR_W-pot_pkg::BIAS_SHIFT){1'b0}},
                      r_lr, {pot_pkg::BIAS_SHIFT{1'b0}}};
    assign cnt_inc = pot_pkg::sat_inc(r_mistakes);

    // Decision, update and epoch bookkeeping for the item in the compute stage.
    always_comb begin
        n_bias     = r_bias;
        n_mistakes = r_mistakes;
        n_epochs   = r_epochs;
        lane_ctl   = '{update: 1'b0, label_pos: r_a_label, clear: 1'b0};
        n_pred     = 1'b0;
        n_miss     = 1'b0;
        n_shown    = r_mistakes;
        n_done     = 1'b0;
        n_conv     = 1'b0;
        n_lim      = 1'b0;
        case (pot_pkg::t_func'(r_a_func))
            pot_pkg::FUNC_TRAIN: begin
                n_pred = pred_pos;
                if (pred_pos != r_a_label) begin
                    n_miss          = 1'b1;
                    lane_ctl.update = b_fire;
                    n_bias          = pot_pkg::sat_weight(r_a_label ? b_ext + db_ext
                                                                    : b_ext - db_ext);
                    n_mistakes      = cnt_inc;
                end
                n_shown = n_mistakes;
                if (r_a_end) begin
                    n_done     = 1'b1;
                    n_epochs   = pot_pkg::sat_inc(r_epochs);
                    n_conv     = (n_mistakes == '0);
                    n_lim      = !n_conv && (n_epochs >= r_max_epochs);
                    n_mistakes = '0;
                end
            end
            pot_pkg::FUNC_CLEAR: begin
                lane_ctl.clear = b_fire;
                n_bias         = '0;
                n_mistakes     = '0;
                n_epochs       = '0;
                n_shown        = '0;
            end
            default: begin
                n_pred = pred_pos;
            end
        endcase
    end

    // Training state commits only when the compute stage moves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias     <= '0;
            r_mistakes <= '0;
            r_epochs   <= '0;
        end else if (b_fire) begin
            r_bias     <= n_bias;
            r_mistakes <= n_mistakes;
            r_epochs   <= n_epochs;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (b_fire) begin
            r_o_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_o_pred  <= n_pred;
            r_o_miss  <= n_miss;
            r_o_shown <= n_shown;
            r_o_done  <= n_done;
            r_o_conv  <= n_conv;
            r_o_lim   <= n_lim;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {4'b0, r_o_lim, r_o_conv, r_o_shown, r_o_miss, r_o_pred};
    assign o_m_tlast  = r_o_done;

    // A finished epoch is either converged or possibly at its limit, never both.
    a_conv_lim_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> !(r_o_conv && r_o_lim))
        else $error("converged and limit_reached set together");

    // Epoch flags appear only on an epoch-end beat.
    a_flags_need_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && (r_o_conv || r_o_lim) |-> r_o_done)
        else $error("epoch flag without epoch_done");

    // A mistake is always counted in the reported total.
    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld && r_o_miss |-> (r_o_shown != '0))
        else $error("mistake reported with zero epoch_mistakes");

    // A beat leaving the compute stage is held in the result register next cycle.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_fire |=> r_o_vld)
        else $error("computed item not presented");

endmodule
